// ===== design/revg_pkg.sv =====
// -----------------------------------------------------------------------------
// revg_pkg
// Shared constants for the rotated ellipse vertex generator: CORDIC gain,
// quarter-turn scale and the arctangent step table.
// -----------------------------------------------------------------------------
package revg_pkg;

  localparam int CORDIC_W  = 32;
  localparam int TRIG_W    = 18;
  localparam int ATAN_LEN  = 24;

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30    = 32'sd652032874;
  localparam logic        [30:0]         HALF_PI_Q30 = 31'd1686629713;

  // atan(2^-i), Q30 radians, rounded
  localparam logic signed [CORDIC_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
    32'sd67021687,  32'sd33543516,  32'sd16775851,  32'sd8388437,
    32'sd4194283,   32'sd2097149,   32'sd1048576,   32'sd524288,
    32'sd262144,    32'sd131072,    32'sd65536,     32'sd32768,
    32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128
  };

endpackage

// ===== design/revg_cordic.sv =====
// -----------------------------------------------------------------------------
// revg_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of a 16-bit turn angle,
// Q16 result, registered at input, per stage and at output while en_i is high.
// -----------------------------------------------------------------------------
module revg_cordic #(
  parameter int STAGES = 16
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic        [15:0]                   turn_i,
  output logic signed [revg_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [revg_pkg::TRIG_W-1:0]   sin_o
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic signed [revg_pkg::CORDIC_W-1:0] x_q [STAGES+1];
  logic signed [revg_pkg::CORDIC_W-1:0] y_q [STAGES+1];
  logic signed [revg_pkg::CORDIC_W-1:0] z_q [STAGES+1];
  logic        [1:0]                    q_q [STAGES+1];

  logic [44:0] zprod;
  logic signed [revg_pkg::CORDIC_W-1:0] c_d, s_d, cr_d, sr_d;
  logic signed [revg_pkg::TRIG_W-1:0]   cos_q, sin_q;

  assign zprod = 45'(turn_i[13:0]) * 45'(revg_pkg::HALF_PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= revg_pkg::GAIN_Q30;
      y_q[0] <= '0;
      z_q[0] <= $signed({1'b0, zprod[44:14]});
      q_q[0] <= turn_i[15:14];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[i+1] <= q_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - revg_pkg::ATAN_Q30[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + revg_pkg::ATAN_Q30[i];
        end
      end
    end
  end

  always_comb begin
    unique case (q_q[STAGES])
      QUAD_0: begin
        c_d = x_q[STAGES];
        s_d = y_q[STAGES];
      end
      QUAD_1: begin
        c_d = -y_q[STAGES];
        s_d = x_q[STAGES];
      end
      QUAD_2: begin
        c_d = -x_q[STAGES];
        s_d = -y_q[STAGES];
      end
      QUAD_3: begin
        c_d = y_q[STAGES];
        s_d = -x_q[STAGES];
      end
    endcase
    cr_d = c_d + 32'sd8192;
    sr_d = s_d + 32'sd8192;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= cr_d[31:14];
      sin_q <= sr_d[31:14];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// ===== design/rotated_ellipse_vertex_generator_unit.sv =====
// -----------------------------------------------------------------------------
// rotated_ellipse_vertex_generator_unit
// Streams vertices of a rotated ellipse outline from vertex indices.
// -----------------------------------------------------------------------------
// Usage:
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//   radii, rotation, phase step, segment count, centre and line-to-centre
//   flag; always ready. Write only while no vertex is in flight.
//   Input channel takes one vertex_index_i beat; output channel returns one
//   beat with point_x_o, point_y_o, in_strip_o and index_valid_o per index.
//   Path: an accepted input beat passes the decode register, then the
//   CORDIC pipeline (input register, TRIG_STAGES iteration stages, output
//   register), four multiply/add stages and the output register.
//   Throughput: one beat per cycle while in_ready_o is high.
//   Reset: config goes to defaults (segment count 1, rest 0), pipeline empty.
//   Receiver stall: the output register holds its beat, one more beat lands
//   in a skid register, then in_ready_o drops and the whole pipeline freezes
//   until the skid register drains. Nothing is dropped or repeated.
// -----------------------------------------------------------------------------
module rotated_ellipse_vertex_generator_unit #(
  parameter int MAX_SEGMENTS = 1024,
  parameter int TRIG_STAGES  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic        [3:0]  cfg_index_i,
  input  logic        [23:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [10:0] vertex_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] point_x_o,
  output logic signed [23:0] point_y_o,
  output logic               in_strip_o,
  output logic               index_valid_o
);

  localparam logic [3:0] REG_RADIUS_H   = 4'd0;
  localparam logic [3:0] REG_RADIUS_V   = 4'd1;
  localparam logic [3:0] REG_ROTATION   = 4'd2;
  localparam logic [3:0] REG_PHASE_STEP = 4'd3;
  localparam logic [3:0] REG_SEG_COUNT  = 4'd4;
  localparam logic [3:0] REG_CENTER_X   = 4'd5;
  localparam logic [3:0] REG_CENTER_Y   = 4'd6;
  localparam logic [3:0] REG_LINE_CTR   = 4'd7;

  localparam int CordicLat = TRIG_STAGES + 2;
  localparam int LineLen   = CordicLat + 4;

  localparam logic signed [57:0] RndHalf = 58'sh8000_0000;
  localparam logic signed [26:0] SatHi   = 27'sd8388607;
  localparam logic signed [26:0] SatLo   = -27'sd8388608;

  typedef enum logic [1:0] {
    VK_NONE    = 2'b00,
    VK_OUTLINE = 2'b01,
    VK_CENTER  = 2'b10
  } vkind_e;

  typedef struct packed {
    logic   valid;
    vkind_e kind;
  } sband_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               strip;
    logic               ivalid;
  } result_t;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [23:0] r;
    if (v > SatHi) r = 24'sh7FFFFF;
    else if (v < SatLo) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // configuration
  logic        [19:0] radius_h_q, radius_v_q;
  logic        [15:0] rotation_q, phase_step_q;
  logic        [10:0] segment_count_q;
  logic signed [23:0] center_x_q, center_y_q;
  logic               line_to_center_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_h_q       <= '0;
      radius_v_q       <= '0;
      rotation_q       <= '0;
      phase_step_q     <= '0;
      segment_count_q  <= 11'd1;
      center_x_q       <= '0;
      center_y_q       <= '0;
      line_to_center_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_RADIUS_H:   radius_h_q       <= cfg_data_i[19:0];
        REG_RADIUS_V:   radius_v_q       <= cfg_data_i[19:0];
        REG_ROTATION:   rotation_q       <= cfg_data_i[15:0];
        REG_PHASE_STEP: phase_step_q     <= cfg_data_i[15:0];
        REG_SEG_COUNT:  segment_count_q  <= cfg_data_i[10:0];
        REG_CENTER_X:   center_x_q       <= $signed(cfg_data_i);
        REG_CENTER_Y:   center_y_q       <= $signed(cfg_data_i);
        REG_LINE_CTR:   line_to_center_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic    en;
  logic    skid_v_q, out_v_q;
  result_t skid_q, out_q, res;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // stage 1: index decode, phase
  logic [10:0] seg_n;
  logic [26:0] phase_prod;
  vkind_e      kind_d;
  sband_t      s1_sb_q;
  logic [15:0] s1_phase_q;

  always_comb begin
    seg_n = segment_count_q;
    if (segment_count_q == '0) seg_n = 11'd1;
    else if (32'(segment_count_q) > MAX_SEGMENTS) seg_n = 11'(MAX_SEGMENTS);
    if (vertex_index_i <= seg_n) kind_d = VK_OUTLINE;
    else if ({1'b0, vertex_index_i} == {1'b0, seg_n} + 12'd1) kind_d = VK_CENTER;
    else kind_d = VK_NONE;
  end

  assign phase_prod = 27'(vertex_index_i) * 27'(phase_step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_sb_q <= '{valid: 1'b0, kind: VK_NONE};
    end else if (en) begin
      s1_sb_q <= '{valid: in_valid_i, kind: kind_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) s1_phase_q <= phase_prod[15:0];
  end

  // trig lanes
  logic signed [revg_pkg::TRIG_W-1:0] cp, sp, cr, sr;

  revg_cordic #(.STAGES(TRIG_STAGES)) u_cordic_phase (
    .clk_i  (clk_i),
    .en_i   (en),
    .turn_i (s1_phase_q),
    .cos_o  (cp),
    .sin_o  (sp)
  );

  revg_cordic #(.STAGES(TRIG_STAGES)) u_cordic_rot (
    .clk_i  (clk_i),
    .en_i   (en),
    .turn_i (rotation_q),
    .cos_o  (cr),
    .sin_o  (sr)
  );

  // sideband line alongside the datapath
  sband_t sb_q [LineLen];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LineLen; k++) sb_q[k] <= '{valid: 1'b0, kind: VK_NONE};
    end else if (en) begin
      sb_q[0] <= s1_sb_q;
      for (int k = 1; k < LineLen; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // M1: radius scaling
  logic signed [38:0] a_q, b_q;
  logic signed [revg_pkg::TRIG_W-1:0] cr_q, sr_q;
  // M2: split products
  logic signed [37:0] acr_h_q, acr_l_q, asr_h_q, asr_l_q;
  logic signed [37:0] bcr_h_q, bcr_l_q, bsr_h_q, bsr_l_q;
  // M3: full products
  logic signed [56:0] acr_q, asr_q, bcr_q, bsr_q;
  // M4: rotated coordinates
  logic signed [57:0] xs_q, ys_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= 39'($signed({1'b0, radius_h_q})) * 39'(cp);
      b_q     <= 39'($signed({1'b0, radius_v_q})) * 39'(sp);
      cr_q    <= cr;
      sr_q    <= sr;
      acr_h_q <= 38'($signed(a_q[38:19])) * 38'(cr_q);
      acr_l_q <= 38'($signed({1'b0, a_q[18:0]})) * 38'(cr_q);
      asr_h_q <= 38'($signed(a_q[38:19])) * 38'(sr_q);
      asr_l_q <= 38'($signed({1'b0, a_q[18:0]})) * 38'(sr_q);
      bcr_h_q <= 38'($signed(b_q[38:19])) * 38'(cr_q);
      bcr_l_q <= 38'($signed({1'b0, b_q[18:0]})) * 38'(cr_q);
      bsr_h_q <= 38'($signed(b_q[38:19])) * 38'(sr_q);
      bsr_l_q <= 38'($signed({1'b0, b_q[18:0]})) * 38'(sr_q);
      acr_q   <= (57'(acr_h_q) <<< 19) + 57'(acr_l_q);
      asr_q   <= (57'(asr_h_q) <<< 19) + 57'(asr_l_q);
      bcr_q   <= (57'(bcr_h_q) <<< 19) + 57'(bcr_l_q);
      bsr_q   <= (57'(bsr_h_q) <<< 19) + 57'(bsr_l_q);
      xs_q    <= 58'(acr_q) - 58'(bsr_q);
      ys_q    <= 58'(asr_q) + 58'(bcr_q);
    end
  end

  // round, add centre, saturate
  sband_t             sb_last;
  logic signed [57:0] xsum, ysum;
  logic signed [26:0] xt, yt;

  assign sb_last = sb_q[LineLen-1];
  assign xsum    = xs_q + RndHalf;
  assign ysum    = ys_q + RndHalf;
  assign xt      = 27'($signed(xsum[57:32])) + 27'(center_x_q);
  assign yt      = 27'($signed(ysum[57:32])) + 27'(center_y_q);

  always_comb begin
    unique case (sb_last.kind)
      VK_OUTLINE: res = '{x: sat24(xt), y: sat24(yt), strip: 1'b1, ivalid: 1'b1};
      VK_CENTER:  res = '{x: center_x_q, y: center_y_q, strip: line_to_center_q,
                          ivalid: 1'b1};
      default:    res = '{x: '0, y: '0, strip: 1'b0, ivalid: 1'b0};
    endcase
  end

  // output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_ready_i || !out_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= sb_last.valid;
    end else if (sb_last.valid) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_ready_i || !out_v_q) out_q <= skid_q;
    end else if (!out_v_q || out_ready_i) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = out_v_q;
  assign point_x_o     = out_q.x;
  assign point_y_o     = out_q.y;
  assign in_strip_o    = out_q.strip;
  assign index_valid_o = out_q.ivalid;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid beat held without output beat");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled while output was free");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_ready_i |=> !skid_v_q && out_v_q)
    else $error("skid beat not moved to output");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_q.ivalid |-> !out_q.strip && out_q.x == '0 && out_q.y == '0)
    else $error("invalid index with nonzero result");

endmodule
